// ----- hw/rtl/qlog_pkg.sv -----
package qlog_pkg;

   localparam int CompW     = 16;
   localparam int TolW      = 15;
   localparam int Lanes     = 3;
   localparam int SqW       = 2 * CompW - 1;
   localparam int SumW      = 2 * CompW;
   localparam int NormW     = 16;
   localparam int RootSteps = SumW / 2;
   localparam int Iters     = 16;
   localparam int GuardBits = 16;
   localparam int AngleFrac = 24;
   localparam int OutFrac   = CompW - 4;
   localparam int DenShift  = AngleFrac - OutFrac;
   localparam int AngW      = 28;
   localparam int MagW      = AngW - 1;
   localparam int CordW     = 36;
   localparam int ProdW     = MagW + CompW;
   localparam int NumW      = ProdW + 2;
   localparam int QuotW     = 16;

   typedef logic signed [CompW-1:0] comp_type;
   typedef logic signed [AngW-1:0]  angle_type;

   localparam comp_type  QOne        = comp_type'(2 ** (CompW - 2));
   localparam comp_type  QNegOne     = -QOne;
   localparam angle_type HalfPiAngle = angle_type'(26353589);

   typedef struct packed {
      comp_type x;
      comp_type y;
      comp_type z;
   } vec_type;

   typedef struct packed {
      comp_type w;
      vec_type  v;
   } quat_type;

   typedef struct packed {
      vec_type          v;
      logic [NormW-1:0] norm;
      logic             below;
   } cside_type;

   function automatic angle_type atan_stage(input int i);
      angle_type a;
      case (i)
         0: a = angle_type'(13176795);
         1: a = angle_type'(7778716);
         2: a = angle_type'(4110060);
         3: a = angle_type'(2086331);
         4: a = angle_type'(1047214);
         5: a = angle_type'(524117);
         6: a = angle_type'(262123);
         7: a = angle_type'(131069);
         default: begin
            if (i <= AngleFrac) a = angle_type'(1) <<< (AngleFrac - i);
            else a = '0;
         end
      endcase
      return a;
   endfunction

endpackage

// ----- hw/rtl/qlog_sqrt.sv -----
module qlog_sqrt (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       en,
   input  logic                       in_valid,
   input  logic [qlog_pkg::SumW-1:0]  radicand,
   input  qlog_pkg::quat_type         in_quat,
   output logic                       out_valid,
   output logic [qlog_pkg::NormW-1:0] root,
   output qlog_pkg::quat_type         out_quat
);
   import qlog_pkg::*;

   logic             valid_ff [RootSteps];
   logic [SumW-1:0]  rem_ff   [RootSteps];
   logic [NormW-1:0] root_ff  [RootSteps];
   quat_type         quat_ff  [RootSteps];

   for (genvar k = 0; k < RootSteps; k++) begin : g_step
      localparam int B = RootSteps - 1 - k;
      logic             vld_src;
      logic [SumW-1:0]  rem_src;
      logic [NormW-1:0] root_src;
      quat_type         quat_src;
      logic [SumW+1:0]  delta;
      logic [SumW+1:0]  rem_ext;
      logic [SumW-1:0]  rem_in;
      logic [NormW-1:0] root_in;

      if (k == 0) begin : g_first
         assign vld_src  = in_valid;
         assign rem_src  = radicand;
         assign root_src = '0;
         assign quat_src = in_quat;
      end else begin : g_next
         assign vld_src  = valid_ff[k-1];
         assign rem_src  = rem_ff[k-1];
         assign root_src = root_ff[k-1];
         assign quat_src = quat_ff[k-1];
      end

      // (r + 2^B)^2 - r^2, r holds only bits above B
      assign delta   = ((SumW+2)'(root_src) << (B + 1)) | ((SumW+2)'(1) << (2 * B));
      assign rem_ext = (SumW+2)'(rem_src);

      always_comb begin
         rem_in  = rem_src;
         root_in = root_src;
         if (rem_ext >= delta) begin
            rem_in  = SumW'(rem_ext - delta);
            root_in = root_src | (NormW'(1) << B);
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[k] <= 1'b0;
         end else if (en) begin
            valid_ff[k] <= vld_src;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[k]  <= rem_in;
            root_ff[k] <= root_in;
            quat_ff[k] <= quat_src;
         end
      end
   end

   assign out_valid = valid_ff[RootSteps-1];
   assign root      = root_ff[RootSteps-1];
   assign out_quat  = quat_ff[RootSteps-1];

endmodule

// ----- hw/rtl/qlog_cordic.sv -----
module qlog_cordic (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       en,
   input  logic                       in_valid,
   input  qlog_pkg::comp_type         w,
   input  qlog_pkg::cside_type        in_side,
   output logic                       out_valid,
   output qlog_pkg::angle_type        angle,
   output qlog_pkg::cside_type        out_side
);
   import qlog_pkg::*;

   logic                    valid_ff [Iters+1];
   logic signed [CordW-1:0] cx_ff    [Iters+1];
   logic signed [CordW-1:0] cy_ff    [Iters+1];
   angle_type               ang_ff   [Iters+1];
   cside_type               side_ff  [Iters+1];

   logic signed [CordW-1:0] wx;
   logic signed [CordW-1:0] ny;
   logic signed [CordW-1:0] cx_in;
   logic signed [CordW-1:0] cy_in;
   angle_type               ang_in;

   assign wx = {{(CordW - CompW - GuardBits){w[CompW-1]}}, w, {GuardBits{1'b0}}};
   assign ny = {{(CordW - NormW - GuardBits){1'b0}}, in_side.norm, {GuardBits{1'b0}}};

   // left half plane: pre-rotate by -pi/2
   always_comb begin
      cx_in  = wx;
      cy_in  = ny;
      ang_in = '0;
      if (wx < 0) begin
         cx_in  = ny;
         cy_in  = -wx;
         ang_in = HalfPiAngle;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff[0] <= 1'b0;
      end else if (en) begin
         valid_ff[0] <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         cx_ff[0]   <= cx_in;
         cy_ff[0]   <= cy_in;
         ang_ff[0]  <= ang_in;
         side_ff[0] <= in_side;
      end
   end

   for (genvar i = 0; i < Iters; i++) begin : g_iter
      localparam angle_type Step = atan_stage(i);
      logic signed [CordW-1:0] dx;
      logic signed [CordW-1:0] dy;
      logic signed [CordW-1:0] cx_in;
      logic signed [CordW-1:0] cy_in;
      angle_type               ang_in;

      assign dx = cx_ff[i] >>> i;
      assign dy = cy_ff[i] >>> i;

      always_comb begin
         if (cy_ff[i] >= 0) begin
            cx_in  = cx_ff[i] + dy;
            cy_in  = cy_ff[i] - dx;
            ang_in = ang_ff[i] + Step;
         end else begin
            cx_in  = cx_ff[i] - dy;
            cy_in  = cy_ff[i] + dx;
            ang_in = ang_ff[i] - Step;
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[i+1] <= 1'b0;
         end else if (en) begin
            valid_ff[i+1] <= valid_ff[i];
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            cx_ff[i+1]   <= cx_in;
            cy_ff[i+1]   <= cy_in;
            ang_ff[i+1]  <= ang_in;
            side_ff[i+1] <= side_ff[i];
         end
      end
   end

   assign out_valid = valid_ff[Iters];
   assign angle     = ang_ff[Iters];
   assign out_side  = side_ff[Iters];

endmodule

// ----- hw/rtl/qlog_div.sv -----
module qlog_div (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       en,
   input  logic                       in_valid,
   input  logic [qlog_pkg::ProdW-1:0] prod     [qlog_pkg::Lanes],
   input  logic                       in_neg   [qlog_pkg::Lanes],
   input  logic [qlog_pkg::NormW-1:0] norm,
   input  logic                       in_below,
   output logic                       out_valid,
   output logic [qlog_pkg::QuotW-1:0] quot     [qlog_pkg::Lanes],
   output logic                       out_neg  [qlog_pkg::Lanes],
   output logic                       out_below
);
   import qlog_pkg::*;

   logic             valid_ff [QuotW+1];
   logic [NormW-1:0] norm_ff  [QuotW+1];
   logic             below_ff [QuotW+1];
   logic [NumW-1:0]  rem_ff   [QuotW+1][Lanes];
   logic [QuotW-1:0] quot_ff  [QuotW+1][Lanes];
   logic             neg_ff   [QuotW+1][Lanes];

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff[0] <= 1'b0;
      end else if (en) begin
         valid_ff[0] <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         norm_ff[0]  <= norm;
         below_ff[0] <= in_below;
      end
   end

   // dividend with half the divisor added for round-to-nearest
   for (genvar l = 0; l < Lanes; l++) begin : g_pre
      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[0][l]  <= (NumW'(prod[l]) << 1) + (NumW'(norm) << (DenShift - 1));
            quot_ff[0][l] <= '0;
            neg_ff[0][l]  <= in_neg[l];
         end
      end
   end

   for (genvar k = 0; k < QuotW; k++) begin : g_step
      localparam int B = QuotW - 1 - k;
      logic [NumW-1:0] dsh;

      assign dsh = NumW'(norm_ff[k]) << (DenShift + B);

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[k+1] <= 1'b0;
         end else if (en) begin
            valid_ff[k+1] <= valid_ff[k];
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            norm_ff[k+1]  <= norm_ff[k];
            below_ff[k+1] <= below_ff[k];
         end
      end

      for (genvar l = 0; l < Lanes; l++) begin : g_lane
         logic [NumW-1:0]  rem_in;
         logic [QuotW-1:0] quot_in;

         always_comb begin
            rem_in  = rem_ff[k][l];
            quot_in = quot_ff[k][l];
            if (rem_ff[k][l] >= dsh) begin
               rem_in  = rem_ff[k][l] - dsh;
               quot_in = quot_ff[k][l] | (QuotW'(1) << B);
            end
         end

         always_ff @(posedge clock) begin
            if (en) begin
               rem_ff[k+1][l]  <= rem_in;
               quot_ff[k+1][l] <= quot_in;
               neg_ff[k+1][l]  <= neg_ff[k][l];
            end
         end
      end
   end

   for (genvar l = 0; l < Lanes; l++) begin : g_out
      assign quot[l]    = quot_ff[QuotW][l];
      assign out_neg[l] = neg_ff[QuotW][l];
   end

   assign out_valid = valid_ff[QuotW];
   assign out_below = below_ff[QuotW];

endmodule

// ----- hw/rtl/quaternion_logarithm_unit.sv -----
// Unit quaternion logarithm: takes w, x, y, z in signed Q2.14 and returns the
// rotation vector 2*atan2(|v|,w)*v/|v| in signed Q4.12. w is clamped to [-1,1].
// When |v| <= zero_tolerance the vector is zero and below_tolerance is set.
// Fully pipelined: one request per cycle while req_stall is low; the path to
// the result register has 2 square/sum stages, 16 square-root stages, 17 CORDIC
// stages, 1 multiply stage, 17 divider stages and 1 output stage. A two-entry
// output buffer lets requests keep flowing while a result waits; req_stall
// rises only when both entries are full.
module quaternion_logarithm_unit (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  qlog_pkg::comp_type        req_quat_w,
   input  qlog_pkg::comp_type        req_quat_x,
   input  qlog_pkg::comp_type        req_quat_y,
   input  qlog_pkg::comp_type        req_quat_z,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output qlog_pkg::comp_type        rsp_rot_x,
   output qlog_pkg::comp_type        rsp_rot_y,
   output qlog_pkg::comp_type        rsp_rot_z,
   output logic                      rsp_below_tolerance,
   input  logic                      csr_wr_en,
   input  logic [qlog_pkg::TolW-1:0] csr_wr_data
);
   import qlog_pkg::*;

   typedef struct packed {
      vec_type rot;
      logic    below;
   } out_type;

   logic            en;
   logic [TolW-1:0] tol_ff;

   // stage 1: clamp and squares
   logic               s1_valid_ff;
   quat_type           s1_quat_ff;
   logic [SqW-1:0]     s1_sq_ff [Lanes];
   comp_type           w_clamp;
   logic signed [SumW-1:0] sq_x;
   logic signed [SumW-1:0] sq_y;
   logic signed [SumW-1:0] sq_z;

   // stage 2: sum of squares
   logic            s2_valid_ff;
   quat_type        s2_quat_ff;
   logic [SumW-1:0] s2_sum_ff;

   logic             sq_valid;
   logic [NormW-1:0] sq_norm;
   quat_type         sq_quat;
   cside_type        cs_in;

   logic      co_valid;
   angle_type co_angle;
   cside_type co_side;

   // multiply stage
   logic             m_valid_ff;
   logic [ProdW-1:0] m_prod_ff [Lanes];
   logic             m_neg_ff  [Lanes];
   logic [NormW-1:0] m_norm_ff;
   logic             m_below_ff;
   logic [MagW-1:0]  ang_mag;
   comp_type         comp_l    [Lanes];
   logic [CompW-1:0] comp_mag  [Lanes];

   logic             dv_valid;
   logic [QuotW-1:0] dv_quot [Lanes];
   logic             dv_neg  [Lanes];
   logic             dv_below;
   comp_type         rot_l   [Lanes];
   out_type          pipe_out;

   logic    rsp_valid_ff;
   out_type rsp_ff;
   logic    skid_valid_ff;
   out_type skid_ff;

   assign en = !skid_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         tol_ff <= '0;
      end else if (csr_wr_en) begin
         tol_ff <= csr_wr_data;
      end
   end

   always_comb begin
      w_clamp = req_quat_w;
      if (req_quat_w > QOne) w_clamp = QOne;
      if (req_quat_w < QNegOne) w_clamp = QNegOne;
   end

   assign sq_x = SumW'(req_quat_x) * SumW'(req_quat_x);
   assign sq_y = SumW'(req_quat_y) * SumW'(req_quat_y);
   assign sq_z = SumW'(req_quat_z) * SumW'(req_quat_z);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else if (en) begin
         s1_valid_ff <= req_valid;
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s1_quat_ff.w   <= w_clamp;
         s1_quat_ff.v.x <= req_quat_x;
         s1_quat_ff.v.y <= req_quat_y;
         s1_quat_ff.v.z <= req_quat_z;
         s1_sq_ff[0]    <= SqW'(sq_x);
         s1_sq_ff[1]    <= SqW'(sq_y);
         s1_sq_ff[2]    <= SqW'(sq_z);
         s2_quat_ff     <= s1_quat_ff;
         s2_sum_ff      <= SumW'(s1_sq_ff[0]) + SumW'(s1_sq_ff[1]) + SumW'(s1_sq_ff[2]);
      end
   end

   qlog_sqrt u_sqrt (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .in_valid (s2_valid_ff),
      .radicand (s2_sum_ff),
      .in_quat  (s2_quat_ff),
      .out_valid(sq_valid),
      .root     (sq_norm),
      .out_quat (sq_quat)
   );

   assign cs_in.v     = sq_quat.v;
   assign cs_in.norm  = sq_norm;
   assign cs_in.below = sq_norm <= NormW'(tol_ff);

   qlog_cordic u_cordic (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .in_valid (sq_valid),
      .w        (sq_quat.w),
      .in_side  (cs_in),
      .out_valid(co_valid),
      .angle    (co_angle),
      .out_side (co_side)
   );

   assign ang_mag   = co_angle[AngW-1] ? MagW'(-co_angle) : MagW'(co_angle);
   assign comp_l[0] = co_side.v.x;
   assign comp_l[1] = co_side.v.y;
   assign comp_l[2] = co_side.v.z;

   for (genvar l = 0; l < Lanes; l++) begin : g_mul
      assign comp_mag[l] = comp_l[l][CompW-1] ? CompW'(-comp_l[l]) : CompW'(comp_l[l]);

      always_ff @(posedge clock) begin
         if (en) begin
            m_prod_ff[l] <= ProdW'(ang_mag) * ProdW'(comp_mag[l]);
            m_neg_ff[l]  <= co_angle[AngW-1] ^ comp_l[l][CompW-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         m_valid_ff <= 1'b0;
      end else if (en) begin
         m_valid_ff <= co_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         m_norm_ff  <= co_side.norm;
         m_below_ff <= co_side.below;
      end
   end

   qlog_div u_div (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .in_valid (m_valid_ff),
      .prod     (m_prod_ff),
      .in_neg   (m_neg_ff),
      .norm     (m_norm_ff),
      .in_below (m_below_ff),
      .out_valid(dv_valid),
      .quot     (dv_quot),
      .out_neg  (dv_neg),
      .out_below(dv_below)
   );

   for (genvar l = 0; l < Lanes; l++) begin : g_sign
      always_comb begin
         if (dv_below) rot_l[l] = '0;
         else if (dv_neg[l]) rot_l[l] = -comp_type'(dv_quot[l]);
         else rot_l[l] = comp_type'(dv_quot[l]);
      end
   end

   assign pipe_out.rot.x = rot_l[0];
   assign pipe_out.rot.y = rot_l[1];
   assign pipe_out.rot.z = rot_l[2];
   assign pipe_out.below = dv_below;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (skid_valid_ff) begin
         if (!rsp_stall) begin
            skid_valid_ff <= 1'b0;
         end
      end else if (!rsp_valid_ff || !rsp_stall) begin
         rsp_valid_ff <= dv_valid;
      end else if (dv_valid) begin
         skid_valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (skid_valid_ff) begin
         if (!rsp_stall) begin
            rsp_ff <= skid_ff;
         end
      end else if (!rsp_valid_ff || !rsp_stall) begin
         rsp_ff <= pipe_out;
      end else begin
         skid_ff <= pipe_out;
      end
   end

   assign req_stall           = skid_valid_ff;
   assign rsp_valid           = rsp_valid_ff;
   assign rsp_rot_x           = rsp_ff.rot.x;
   assign rsp_rot_y           = rsp_ff.rot.y;
   assign rsp_rot_z           = rsp_ff.rot.z;
   assign rsp_below_tolerance = rsp_ff.below;

   a_skid_needs_rsp: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> rsp_valid_ff)
      else $error("skid entry without a held response");

   a_skid_holds: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff && rsp_stall |=> skid_valid_ff)
      else $error("skid entry dropped while response stalled");

   a_below_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.below |-> rsp_ff.rot == '0)
      else $error("nonzero rotation with below_tolerance set");

endmodule

// ----- verif/testbench.sv -----
`timescale 1ns / 1ps

module testbench;
   import qlog_pkg::*;

   typedef struct {
      comp_type rot_x;
      comp_type rot_y;
      comp_type rot_z;
      logic     below;
   } rotvec_type;

   logic clock = 0;
   logic reset = 1;
   logic req_valid = 0;
   logic req_stall;
   comp_type req_quat_w = '0, req_quat_x = '0, req_quat_y = '0, req_quat_z = '0;
   logic rsp_valid;
   logic rsp_stall = 0;
   comp_type rsp_rot_x, rsp_rot_y, rsp_rot_z;
   logic rsp_below_tolerance;
   logic csr_wr_en = 0;
   logic [TolW-1:0] csr_wr_data = '0;

   logic [TolW-1:0] tolerance = '0;
   rotvec_type expected_rot[$];
   int errors = 0;
   int sent = 0;
   int received = 0;
   int below_seen = 0;
   int idle_cycles = 0;
   bit quiet = 0;
   int stall_left = 0;

   always #1 clock = ~clock;

   quaternion_logarithm_unit u_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_quat_w(req_quat_w), .req_quat_x(req_quat_x),
      .req_quat_y(req_quat_y), .req_quat_z(req_quat_z),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_rot_x(rsp_rot_x), .rsp_rot_y(rsp_rot_y), .rsp_rot_z(rsp_rot_z),
      .rsp_below_tolerance(rsp_below_tolerance),
      .csr_wr_en(csr_wr_en), .csr_wr_data(csr_wr_data)
   );

   function automatic longint atan_step(input int i);
      longint head[8] = '{13176795, 7778716, 4110060, 2086331,
                          1047214, 524117, 262123, 131069};
      if (i < 8) return head[i];
      if (i <= AngleFrac) return longint'(1) << (AngleFrac - i);
      return 0;
   endfunction

   function automatic longint isqrt(input longint unsigned n);
      longint unsigned res = 0;
      longint unsigned b = longint'(1) << 62;
      while (b > n) b = b >> 2;
      while (b != 0) begin
         if (n >= res + b) begin
            n = n - (res + b);
            res = (res >> 1) + b;
         end else begin
            res = res >> 1;
         end
         b = b >> 2;
      end
      return res;
   endfunction

   function automatic comp_type scale_axis(input longint ang, input longint c,
                                           input longint norm);
      longint num, den, mag, q;
      num = 2 * ang * c;
      den = norm <<< DenShift;
      mag = (num < 0) ? -num : num;
      q = (mag + den / 2) / den;
      if (num < 0) q = -q;
      return comp_type'(q);
   endfunction

   function automatic rotvec_type quat_log(input comp_type qw, qx, qy, qz);
      rotvec_type r;
      longint w, x, y, z, norm, cx, cy, ang, dx, dy, t;
      w = qw; x = qx; y = qy; z = qz;
      if (w > 16384) w = 16384;
      if (w < -16384) w = -16384;
      norm = isqrt(x * x + y * y + z * z);
      if (norm <= longint'(tolerance)) begin
         r = '{0, 0, 0, 1'b1};
         return r;
      end
      cx = w <<< GuardBits;
      cy = norm <<< GuardBits;
      ang = 0;
      if (cx < 0) begin
         t = cx; cx = cy; cy = -t;
         ang = 26353589;
      end
      for (int i = 0; i < Iters; i++) begin
         dx = cx >>> i;
         dy = cy >>> i;
         if (cy >= 0) begin
            cx += dy; cy -= dx; ang += atan_step(i);
         end else begin
            cx -= dy; cy += dx; ang -= atan_step(i);
         end
      end
      r.rot_x = scale_axis(ang, x, norm);
      r.rot_y = scale_axis(ang, y, norm);
      r.rot_z = scale_axis(ang, z, norm);
      r.below = 1'b0;
      return r;
   endfunction

   function automatic int pick_gap();
      int r = $urandom_range(0, 99);
      if (quiet || r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   task automatic send_quat(input comp_type w, x, y, z);
      int gap = pick_gap();
      repeat (gap) begin
         @(negedge clock);
         req_valid = 0;
      end
      @(negedge clock);
      req_valid = 1;
      req_quat_w = w; req_quat_x = x; req_quat_y = y; req_quat_z = z;
      do @(posedge clock); while (req_stall);
      expected_rot.push_back(quat_log(w, x, y, z));
      sent++;
   endtask

   task automatic drain();
      @(negedge clock);
      req_valid = 0;
      while (expected_rot.size() != 0) @(posedge clock);
      repeat (60) @(posedge clock);
   endtask

   task automatic write_tolerance(input logic [TolW-1:0] v);
      drain();
      @(negedge clock);
      csr_wr_en = 1;
      csr_wr_data = v;
      @(negedge clock);
      csr_wr_en = 0;
      tolerance = v;
   endtask

   // response-side stall: random stretches, none started while quiet
   always @(negedge clock) begin
      if (stall_left > 0) begin
         stall_left--;
         rsp_stall = 1;
      end else begin
         rsp_stall = 0;
         if ($urandom_range(0, 9) == 0) stall_left = pick_gap();
      end
   end

   always @(posedge clock) begin
      rotvec_type e;
      if (rsp_valid && !rsp_stall) begin
         received++;
         if (expected_rot.size() == 0) begin
            $error("result with nothing expected");
            errors++;
         end else begin
            e = expected_rot.pop_front();
            if (rsp_rot_x !== e.rot_x) begin
               $error("rot_x expected %0d got %0d", e.rot_x, rsp_rot_x); errors++;
            end
            if (rsp_rot_y !== e.rot_y) begin
               $error("rot_y expected %0d got %0d", e.rot_y, rsp_rot_y); errors++;
            end
            if (rsp_rot_z !== e.rot_z) begin
               $error("rot_z expected %0d got %0d", e.rot_z, rsp_rot_z); errors++;
            end
            if (rsp_below_tolerance !== e.below) begin
               $error("below_tolerance expected %0b got %0b", e.below,
                      rsp_below_tolerance);
               errors++;
            end
            if (e.below) below_seen++;
         end
      end
   end

   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles > 5000) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   task automatic test_directed();
      send_quat(16384, 0, 0, 0);
      send_quat(-16384, 0, 0, 0);
      send_quat(0, 16384, 0, 0);
      send_quat(0, 0, 16384, 0);
      send_quat(0, 0, 0, 16384);
      send_quat(-16384, 1, 0, 0);
      send_quat(32767, 100, -100, 50);
      send_quat(-32768, 100, -100, 50);
      send_quat(-32768, -32768, -32768, -32768);
      send_quat(32767, 32767, 32767, 32767);
      send_quat(0, -32768, 32767, -32768);
      send_quat(11585, 11585, 0, 0);
      send_quat(-11585, 0, -11585, 0);
      send_quat(0, 1, 0, 0);
      send_quat(-1, 0, 0, -1);
      send_quat(16000, 300, -200, 100);
      send_quat(-5, 3, 4, 0);
   endtask

   task automatic test_tolerance();
      logic [TolW-1:0] levels[4] = '{15'd5, 15'd1000, 15'd32767, 15'd0};
      foreach (levels[k]) begin
         write_tolerance(levels[k]);
         for (int i = 0; i < 12; i++) begin
            int m = (i < 6) ? 8 : 2000;
            send_quat(comp_type'($urandom), comp_type'($urandom_range(0, 2 * m) - m),
                      comp_type'($urandom_range(0, 2 * m) - m),
                      comp_type'($urandom_range(0, 2 * m) - m));
         end
         send_quat(0, comp_type'(levels[k]), 0, 0);
         send_quat(0, 0, comp_type'(levels[k] + 1), 0);
      end
   endtask

   task automatic test_random();
      int mode;
      int shift;
      for (int i = 0; i < 900; i++) begin
         quiet = (i % 300) >= 250;
         mode = $urandom_range(0, 3);
         shift = $urandom_range(0, 15);
         if (mode == 0) begin
            send_quat(comp_type'($urandom), comp_type'($urandom),
                      comp_type'($urandom), comp_type'($urandom));
         end else begin
            send_quat(comp_type'($urandom_range(0, 32768) - 16384),
                      comp_type'((int'($urandom_range(0, 16384)) - 8192) >>> shift),
                      comp_type'((int'($urandom_range(0, 16384)) - 8192) >>> shift),
                      comp_type'((int'($urandom_range(0, 16384)) - 8192) >>> shift));
         end
         if (i == 450) write_tolerance(15'd40);
      end
      quiet = 0;
   endtask

   initial begin
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 0;
      test_directed();
      test_tolerance();
      test_random();
      drain();
      $display("Sent %0d quaternions, checked %0d rotation vectors (%0d below tolerance)",
               sent, received, below_seen);
      $display("Tolerance settings 0, 5, 40, 1000 and 32767 exercised under random stalls");
      if (errors == 0 && expected_rot.size() == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
